/* hw/rtl/u8u16_pkg.sv */
`default_nettype none

package u8u16_pkg;

  localparam logic [5:0]  UNIT_LIMIT_RESET = 6'd36;
  localparam logic [5:0]  UNIT_LIMIT_MAX   = 6'd63;
  localparam logic [15:0] SURR_HI_BASE     = 16'hD800;
  localparam logic [15:0] SURR_LO_BASE     = 16'hDC00;
  localparam logic [20:0] SUPP_BASE        = 21'h10000;
  localparam logic [20:0] CP_MAX           = 21'h10FFFF;
  localparam logic [9:0]  TEN_BIT_MASK     = 10'h3FF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       begins_string;
  } in_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        unit_present;
    logic        run_end;
    logic [5:0]  units_written;
  } out_t;

  // what the byte taken this cycle asks for
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_ONE,
    ACT_PAIR,
    ACT_FINISH
  } act_t;

  typedef struct packed {
    logic accept;
    logic emit_hi;
    logic emit_lo;
    logic pad;
    logic close;
  } cmd_t;

  typedef struct packed {
    act_t act;
    logic out_free;
    logic lo_fills;
    logic pad_done;
  } status_t;

endpackage

`default_nettype wire

/* hw/rtl/u8u16_ctrl.sv */
`default_nettype none

module u8u16_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire u8u16_pkg::status_t sts,
  output u8u16_pkg::cmd_t        cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HI,
    S_LO,
    S_PAD,
    S_CLOSE
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (sts.act)
            u8u16_pkg::ACT_NONE:   state_nxt = S_IDLE;
            u8u16_pkg::ACT_ONE:    state_nxt = S_LO;
            u8u16_pkg::ACT_PAIR:   state_nxt = S_HI;
            u8u16_pkg::ACT_FINISH: state_nxt = S_PAD;
            default:               state_nxt = S_IDLE;
          endcase
        end
      end
      S_HI: begin
        if (sts.out_free) begin
          cmd.emit_hi = 1'b1;
          state_nxt   = S_LO;
        end
      end
      S_LO: begin
        if (sts.out_free) begin
          cmd.emit_lo = 1'b1;
          state_nxt   = sts.lo_fills ? S_PAD : S_IDLE;
        end
      end
      S_PAD: begin
        if (sts.pad_done) begin
          state_nxt = S_CLOSE;
        end else if (sts.out_free) begin
          cmd.pad = 1'b1;
        end
      end
      S_CLOSE: begin
        if (sts.out_free) begin
          cmd.close = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/u8u16_dp.sv */
`default_nettype none

module u8u16_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire u8u16_pkg::in_t     in_data,
  input  wire logic               cfg_valid,
  input  wire logic [5:0]         cfg_data,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output u8u16_pkg::out_t         out_data,
  input  wire u8u16_pkg::cmd_t    cmd,
  output u8u16_pkg::status_t      sts
);

  logic [5:0]  limit_r;
  logic [20:0] partial_r, partial_nxt;
  logic [1:0]  cont_r, cont_nxt;
  logic [5:0]  units_r;
  logic [5:0]  pad_r;
  logic        done_r;
  logic [15:0] hi_r, lo_r, hi_nxt, lo_nxt;
  logic        out_valid_r;
  u8u16_pkg::out_t out_r;

  logic [5:0]  lim;
  logic        eff_done;
  logic [5:0]  eff_units;
  logic [1:0]  eff_cont;
  logic [20:0] eff_partial;
  logic [7:0]  b;
  logic [20:0] cp;
  logic [20:0] cp_off;
  logic        have_cp;
  logic [6:0]  units_inc;
  u8u16_pkg::act_t act;

  assign lim = (limit_r < u8u16_pkg::UNIT_LIMIT_MAX) ? limit_r : u8u16_pkg::UNIT_LIMIT_MAX;
  assign b   = in_data.data_byte;

  assign eff_done    = in_data.begins_string ? 1'b0  : done_r;
  assign eff_units   = in_data.begins_string ? 6'd0  : units_r;
  assign eff_cont    = in_data.begins_string ? 2'd0  : cont_r;
  assign eff_partial = in_data.begins_string ? 21'd0 : partial_r;

  assign units_inc = {1'b0, units_r} + 7'd1;

  // byte decode against the state as it stands after a begin-string clear
  always_comb begin
    act         = u8u16_pkg::ACT_NONE;
    partial_nxt = eff_partial;
    cont_nxt    = eff_cont;
    cp          = '0;
    have_cp     = 1'b0;
    if (eff_done) begin
      act = u8u16_pkg::ACT_NONE;
    end else if (eff_units >= lim) begin
      act = u8u16_pkg::ACT_FINISH;
    end else if (eff_cont != 2'd0) begin
      if (b[7:6] != 2'b10) begin
        act = u8u16_pkg::ACT_FINISH;
      end else begin
        partial_nxt = {eff_partial[14:0], b[5:0]};
        cont_nxt    = eff_cont - 2'd1;
        if (cont_nxt == 2'd0) begin
          cp          = {eff_partial[14:0], b[5:0]};
          partial_nxt = '0;
          have_cp     = 1'b1;
        end
      end
    end else if (b == 8'd0) begin
      act = u8u16_pkg::ACT_FINISH;
    end else if (b[7] == 1'b0) begin
      cp      = {13'd0, b};
      have_cp = 1'b1;
    end else if (b[7:5] == 3'b110) begin
      partial_nxt = {16'd0, b[4:0]};
      cont_nxt    = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      partial_nxt = {17'd0, b[3:0]};
      cont_nxt    = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      partial_nxt = {18'd0, b[2:0]};
      cont_nxt    = 2'd3;
    end else begin
      act = u8u16_pkg::ACT_FINISH;
    end

    if (have_cp) begin
      if (cp < u8u16_pkg::SUPP_BASE) begin
        act = u8u16_pkg::ACT_ONE;
      end else if (cp <= u8u16_pkg::CP_MAX) begin
        // a pair needs room for both halves
        if (({1'b0, eff_units} + 7'd1) >= {1'b0, lim}) begin
          act = u8u16_pkg::ACT_FINISH;
        end else begin
          act = u8u16_pkg::ACT_PAIR;
        end
      end else begin
        act = u8u16_pkg::ACT_FINISH;
      end
    end
    if (act == u8u16_pkg::ACT_FINISH) begin
      partial_nxt = '0;
      cont_nxt    = '0;
    end
  end

  assign cp_off = cp - u8u16_pkg::SUPP_BASE;

  always_comb begin
    if (act == u8u16_pkg::ACT_PAIR) begin
      hi_nxt = u8u16_pkg::SURR_HI_BASE + {6'd0, cp_off[19:10]};
      lo_nxt = u8u16_pkg::SURR_LO_BASE + {6'd0, cp_off[9:0] & u8u16_pkg::TEN_BIT_MASK};
    end else begin
      hi_nxt = '0;
      lo_nxt = cp[15:0];
    end
  end

  assign sts.act      = act;
  assign sts.out_free = !out_valid_r || !out_stall;
  assign sts.lo_fills = (units_inc >= {1'b0, lim});
  assign sts.pad_done = (pad_r >= lim);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= u8u16_pkg::UNIT_LIMIT_RESET;
      partial_r   <= '0;
      cont_r      <= '0;
      units_r     <= '0;
      pad_r       <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        limit_r <= cfg_data;
      end
      if (cmd.accept) begin
        partial_r <= partial_nxt;
        cont_r    <= cont_nxt;
        units_r   <= eff_units;
        pad_r     <= eff_units;
        done_r    <= eff_done;
      end
      if (cmd.emit_hi || cmd.emit_lo) begin
        units_r <= units_inc[5:0];
        pad_r   <= units_inc[5:0];
      end
      if (cmd.pad) begin
        pad_r <= pad_r + 6'd1;
      end
      if (cmd.close) begin
        done_r <= 1'b1;
      end
      if (cmd.emit_hi || cmd.emit_lo || cmd.pad || cmd.close) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
    if (cmd.emit_hi) begin
      out_r <= '{code_unit: hi_r, unit_present: 1'b1, run_end: 1'b0, units_written: 6'd0};
    end else if (cmd.emit_lo) begin
      out_r <= '{code_unit: lo_r, unit_present: 1'b1, run_end: 1'b0, units_written: 6'd0};
    end else if (cmd.pad) begin
      out_r <= '{code_unit: 16'd0, unit_present: 1'b1, run_end: 1'b0, units_written: 6'd0};
    end else if (cmd.close) begin
      out_r <= '{code_unit: 16'd0, unit_present: 1'b0, run_end: 1'b1,
                 units_written: units_r};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

/* hw/rtl/utf8_to_utf16le_transcoder.sv */
// UTF-8 to UTF-16 transcoder.
// Input channel in_valid/in_stall/in_data carries one UTF-8 byte per word,
// with begins_string set on the first byte of a string. Output channel
// out_valid/out_stall/out_data carries one UTF-16 unit, padding unit or
// closing word (run_end set, units_written holding the real unit count).
// cfg_valid/cfg_ready/cfg_data writes the unit limit; cfg_ready is always
// high and the limit should only change while the block is idle.
// A byte that completes no codepoint is only accepted. A byte that yields one
// unit is accepted, then loaded into the output register; a surrogate pair
// loads the high unit, then the low unit. Ending a string sends each padding
// unit in turn, then does the padding check and sends the closing word.
// The controller holds in_stall while it has units to send, so bytes are
// taken one at a time; the output register lets a unit wait for the
// receiver while the next byte is accepted.
// When out_stall is high a valid output word holds and the controller waits.
// Synchronous reset (rst_n low) sets the limit to 36, clears the decoder and
// the unit count, and leaves the block ready for a new string.
`default_nettype none

module utf8_to_utf16le_transcoder (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire u8u16_pkg::in_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output u8u16_pkg::out_t      out_data,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [5:0]      cfg_data
);

  u8u16_pkg::cmd_t    cmd;
  u8u16_pkg::status_t sts;

  assign cfg_ready = 1'b1;

  u8u16_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  u8u16_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire
